/* design/mlpf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types of the matrix local peak finder.
// No dependencies; every other design file but mlpf_line_store uses this package.
package mlpf_pkg;

    // Default sizes for the top-level parameters.
    parameter int MAX_ROWS_DEF   = 1024;
    parameter int MAX_COLS_DEF   = 1024;
    parameter int VALUE_BITS_DEF = 32;

    // Configuration port.
    parameter int CFG_IDX_W  = 1;
    parameter int CFG_DATA_W = 11;
    parameter logic [CFG_IDX_W-1:0]  REG_NUM_ROWS = 1'b0;
    parameter logic [CFG_IDX_W-1:0]  REG_NUM_COLS = 1'b1;
    parameter logic [CFG_DATA_W-1:0] DIM_RESET    = 11'd1024;

    // Input command codes.
    parameter logic CMD_ELEMENT = 1'b0;
    parameter logic CMD_DRAIN   = 1'b1;

    // Result field widths and the saturation point of the peak counter.
    parameter int POS_W   = 10;
    parameter int COUNT_W = 21;
    parameter logic [COUNT_W-1:0] COUNT_MAX = 21'h1FFFFF;

    // What a transaction does once it reaches the compare stage.
    typedef enum logic [1:0] {
        STEP_FILL,
        STEP_DECIDE,
        STEP_DRAIN,
        STEP_FINAL
    } step_kind_t;

endpackage

/* design/mlpf_item_if.sv */
`timescale 1ns / 1ps
// Input channel of the matrix local peak finder: valid/ready plus item payload.
// Depends on mlpf_pkg for the default value width.
interface mlpf_item_if #(
    parameter int VALUE_BITS = mlpf_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

/* design/mlpf_result_if.sv */
`timescale 1ns / 1ps
// Output channel of the matrix local peak finder: valid/ready plus result payload.
// Depends on mlpf_pkg for the field widths.
interface mlpf_result_if;
    import mlpf_pkg::*;

    logic               valid;
    logic               ready;
    logic               peak_found;
    logic [POS_W-1:0]   peak_row;
    logic [POS_W-1:0]   peak_col;
    logic [COUNT_W-1:0] peak_count;
    logic               is_last;

    modport source (output valid, output peak_found, output peak_row, output peak_col,
                    output peak_count, output is_last, input ready);
    modport sink   (input valid, input peak_found, input peak_row, input peak_col,
                    input peak_count, input is_last, output ready);
endinterface

/* design/mlpf_line_store.sv */
`timescale 1ns / 1ps
// Three-row line store: one write port and two registered read ports.
// Stand-alone memory; no package dependency.
module mlpf_line_store #(
    parameter int DEPTH  = 3072,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [DATA_W-1:0]        rdata_a,
    output logic [DATA_W-1:0]        rdata_b
);
    logic [DATA_W-1:0] line_mem [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            line_mem[waddr] <= wdata;
        end
    end

    // Read ports; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_a_reg <= line_mem[raddr_a];
            rd_b_reg <= line_mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;
endmodule

/* design/matrix_local_peak_finder.sv */
`timescale 1ns / 1ps
// Four-neighbor peak finder over a row-major matrix stream.
// Depends on mlpf_pkg, mlpf_item_if, mlpf_result_if and mlpf_line_store.
//
// The block takes one transaction per clock cycle whenever the result register
// is free or being emptied; each item is registered at the compare stage and any
// result it causes in the result register. That rate comes from the line store:
// each element makes one write and two reads (the right neighbor of the row being
// decided, or a prefetch of the next row's first column at the end of a row, and
// the element above), and the left neighbor and center come from a two-entry
// window register. An element of row r-1 is decided when the element below it
// arrives; after the last element, num_cols drain ticks decide the last row and
// one more drain tick returns the final count with is_last set. Extra elements
// and early drain ticks are taken and dropped. The line store needs no clearing
// pass after reset. Writing num_rows or num_cols restarts the stream.
module matrix_local_peak_finder #(
    parameter int MAX_ROWS   = mlpf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = mlpf_pkg::MAX_COLS_DEF,
    parameter int VALUE_BITS = mlpf_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mlpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlpf_pkg::CFG_DATA_W-1:0]   cfg_data,
    mlpf_item_if.sink                         item,
    mlpf_result_if.source                     result
);
    import mlpf_pkg::*;

    localparam int ROW_IW = $clog2(MAX_ROWS);
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_IW = $clog2(MAX_COLS);
    localparam int COL_CW = $clog2(MAX_COLS + 1);
    localparam int DEPTH  = 3 * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RCMP_W = (CFG_DATA_W > ROW_CW) ? CFG_DATA_W : ROW_CW;
    localparam int CCMP_W = (CFG_DATA_W > COL_CW) ? CFG_DATA_W : COL_CW;
    localparam logic [VALUE_BITS-1:0] SIGN_FLIP = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    typedef logic [1:0] slot_t;

    // Transaction held at the compare stage.
    typedef struct packed {
        step_kind_t            kind;
        logic [ROW_IW-1:0]     row;
        logic [COL_IW-1:0]     col;
        logic                  has_left;
        logic                  has_right;
        logic                  has_up;
        logic                  has_down;
        logic                  fwd;
        logic [VALUE_BITS-1:0] key;
    } s1_t;

    // Base address of a row slot in the line store.
    function automatic logic [ADDR_W-1:0] slot_base(input slot_t slot);
        logic [ADDR_W-1:0] base;
        unique case (slot)
            2'd0:    base = '0;
            2'd1:    base = ADDR_W'(MAX_COLS);
            2'd2:    base = ADDR_W'(2 * MAX_COLS);
            default: base = '0;
        endcase
        return base;
    endfunction

    // Slot one row back, modulo three.
    function automatic slot_t slot_back(input slot_t slot);
        slot_t prev;
        unique case (slot)
            2'd0:    prev = 2'd2;
            2'd1:    prev = 2'd0;
            2'd2:    prev = 2'd1;
            default: prev = 2'd0;
        endcase
        return prev;
    endfunction

    logic [CFG_DATA_W-1:0] num_rows_reg, num_rows_next;
    logic [CFG_DATA_W-1:0] num_cols_reg, num_cols_next;
    logic [ROW_CW-1:0]     in_row_reg, in_row_next;
    logic [COL_IW-1:0]     in_col_reg, in_col_next;
    logic [COL_CW-1:0]     drain_reg, drain_next;
    slot_t                 slot_reg, slot_next;
    logic [COUNT_W-1:0]    peak_total_reg, peak_total_next;
    logic                  s1_valid_reg, s1_valid_next;
    s1_t                   s1_reg, s1_next;
    logic [VALUE_BITS-1:0] win_c_reg, win_c_next;
    logic [VALUE_BITS-1:0] win_l_reg, win_l_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [POS_W-1:0]      out_row_reg, out_row_next;
    logic [POS_W-1:0]      out_col_reg, out_col_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;

    logic [ROW_CW-1:0]     nr_eff;
    logic [COL_CW-1:0]     nc_eff;
    logic [COL_CW-1:0]     col_ext;
    logic                  last_col;
    logic                  row_open;
    logic                  item_fire;
    logic                  s0_load;
    logic                  mem_we;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr_a;
    logic [ADDR_W-1:0]     raddr_b;
    logic [VALUE_BITS-1:0] rdata_a;
    logic [VALUE_BITS-1:0] rdata_b;
    slot_t                 slot_prev;
    slot_t                 slot_prev2;
    logic                  s1_fire;
    logic                  s1_decides;
    logic                  is_peak;
    logic [COUNT_W-1:0]    count_inc;

    // Register values out of range are taken as the nearest legal size.
    always_comb
    begin
        priority if (num_rows_reg == '0)
        begin
            nr_eff = ROW_CW'(1);
        end
        else if (RCMP_W'(num_rows_reg) > RCMP_W'(MAX_ROWS))
        begin
            nr_eff = ROW_CW'(MAX_ROWS);
        end
        else
        begin
            nr_eff = ROW_CW'(num_rows_reg);
        end

        priority if (num_cols_reg == '0)
        begin
            nc_eff = COL_CW'(1);
        end
        else if (CCMP_W'(num_cols_reg) > CCMP_W'(MAX_COLS))
        begin
            nc_eff = COL_CW'(MAX_COLS);
        end
        else
        begin
            nc_eff = COL_CW'(num_cols_reg);
        end
    end

    assign col_ext    = COL_CW'(in_col_reg);
    assign last_col   = (col_ext + COL_CW'(1)) == nc_eff;
    assign row_open   = in_row_reg < nr_eff;
    assign slot_prev  = slot_back(slot_reg);
    assign slot_prev2 = slot_back(slot_prev);
    assign item_fire  = item.valid && item.ready;

    // Compare stage moves on when the result register is free or being taken.
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_fire;

    // Configuration registers.
    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS: num_rows_next = cfg_data;
                REG_NUM_COLS: num_cols_next = cfg_data;
                default:      num_rows_next = num_rows_reg;
            endcase
        end
    end

    // Input stage: stream position, line store accesses and the transaction
    // handed to the compare stage.
    always_comb
    begin
        in_row_next        = in_row_reg;
        in_col_next        = in_col_reg;
        drain_next         = drain_reg;
        slot_next          = slot_reg;
        s0_load            = 1'b0;
        mem_we             = 1'b0;
        waddr              = slot_base(slot_reg) + ADDR_W'(in_col_reg);
        raddr_a            = slot_base(slot_prev);
        raddr_b            = slot_base(slot_prev2);
        s1_next.kind       = STEP_FILL;
        s1_next.row        = '0;
        s1_next.col        = '0;
        s1_next.has_left   = 1'b0;
        s1_next.has_right  = 1'b0;
        s1_next.has_up     = 1'b0;
        s1_next.has_down   = 1'b0;
        s1_next.fwd        = 1'b0;
        s1_next.key        = $unsigned(item.value) ^ SIGN_FLIP;

        if (cfg_we)
        begin
            in_row_next = '0;
            in_col_next = '0;
            drain_next  = '0;
            slot_next   = '0;
        end
        else if (item_fire)
        begin
            if (item.cmd == CMD_ELEMENT)
            begin
                if (row_open)
                begin
                    s0_load           = 1'b1;
                    mem_we            = 1'b1;
                    s1_next.kind      = (in_row_reg != '0) ? STEP_DECIDE : STEP_FILL;
                    s1_next.row       = ROW_IW'(in_row_reg - ROW_CW'(1));
                    s1_next.col       = in_col_reg;
                    s1_next.has_left  = in_col_reg != '0;
                    s1_next.has_right = !last_col;
                    s1_next.has_up    = in_row_reg >= ROW_CW'(2);
                    s1_next.has_down  = 1'b1;
                    // A one-column row reads back the element written right now.
                    s1_next.fwd       = last_col && (nc_eff == COL_CW'(1));
                    raddr_b           = slot_base(slot_prev2) + ADDR_W'(in_col_reg);
                    if (last_col)
                    begin
                        // Prefetch column zero of this row as the next center.
                        raddr_a     = slot_base(slot_reg);
                        in_col_next = '0;
                        in_row_next = in_row_reg + ROW_CW'(1);
                        slot_next   = slot_back(slot_prev);
                    end
                    else
                    begin
                        raddr_a     = slot_base(slot_prev) + ADDR_W'(col_ext + COL_CW'(1));
                        in_col_next = in_col_reg + COL_IW'(1);
                    end
                end
            end
            else if (!row_open)
            begin
                s0_load = 1'b1;
                if (drain_reg < nc_eff)
                begin
                    s1_next.kind      = STEP_DRAIN;
                    s1_next.row       = ROW_IW'(nr_eff - ROW_CW'(1));
                    s1_next.col       = COL_IW'(drain_reg);
                    s1_next.has_left  = drain_reg != '0;
                    s1_next.has_right = (drain_reg + COL_CW'(1)) < nc_eff;
                    s1_next.has_up    = nr_eff >= ROW_CW'(2);
                    raddr_b           = slot_base(slot_prev2) + ADDR_W'(drain_reg);
                    if (s1_next.has_right)
                    begin
                        raddr_a = slot_base(slot_prev) + ADDR_W'(drain_reg + COL_CW'(1));
                    end
                    drain_next = drain_reg + COL_CW'(1);
                end
                else
                begin
                    s1_next.kind = STEP_FINAL;
                    in_row_next  = '0;
                    in_col_next  = '0;
                    drain_next   = '0;
                    slot_next    = '0;
                end
            end
        end
    end

    mlpf_line_store #(
        .DEPTH  (DEPTH),
        .DATA_W (VALUE_BITS)
    ) u_line_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (waddr),
        .wdata   (s1_next.key),
        .re      (s0_load),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Compare stage: center and left from the window, right and up from memory, down from the item.
    assign s1_decides = (s1_reg.kind == STEP_DECIDE) || (s1_reg.kind == STEP_DRAIN);
    assign is_peak = s1_decides
        && !(s1_reg.has_left  && (win_c_reg < win_l_reg))
        && !(s1_reg.has_right && (win_c_reg < rdata_a))
        && !(s1_reg.has_up    && (win_c_reg < rdata_b))
        && !(s1_reg.has_down  && (win_c_reg < s1_reg.key));
    assign count_inc = (peak_total_reg != COUNT_MAX) ? peak_total_reg + COUNT_W'(1)
                                                     : peak_total_reg;

    always_comb
    begin
        s1_valid_next = s0_load ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        win_c_next      = win_c_reg;
        win_l_next      = win_l_reg;
        peak_total_next = peak_total_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_found_next  = out_found_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            peak_total_next = '0;
        end
        else if (s1_fire)
        begin
            if (s1_reg.kind == STEP_FINAL)
            begin
                peak_total_next = '0;
                out_valid_next  = 1'b1;
                out_found_next  = 1'b0;
                out_row_next    = '0;
                out_col_next    = '0;
                out_count_next  = peak_total_reg;
                out_last_next   = 1'b1;
            end
            else
            begin
                // Slide the window along the row being decided.
                win_l_next = win_c_reg;
                win_c_next = s1_reg.fwd ? s1_reg.key : rdata_a;
                if (is_peak)
                begin
                    peak_total_next = count_inc;
                    out_valid_next  = 1'b1;
                    out_found_next  = 1'b1;
                    out_row_next    = POS_W'(s1_reg.row);
                    out_col_next    = POS_W'(s1_reg.col);
                    out_count_next  = count_inc;
                    out_last_next   = 1'b0;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= DIM_RESET;
            num_cols_reg   <= DIM_RESET;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            drain_reg      <= '0;
            slot_reg       <= '0;
            peak_total_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            num_rows_reg   <= num_rows_next;
            num_cols_reg   <= num_cols_next;
            in_row_reg     <= in_row_next;
            in_col_reg     <= in_col_next;
            drain_reg      <= drain_next;
            slot_reg       <= slot_next;
            peak_total_reg <= peak_total_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s0_load)
        begin
            s1_reg <= s1_next;
        end
        win_c_reg     <= win_c_next;
        win_l_reg     <= win_l_next;
        out_found_reg <= out_found_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.peak_found = out_found_reg;
    assign result.peak_row   = out_row_reg;
    assign result.peak_col   = out_col_reg;
    assign result.peak_count = out_count_reg;
    assign result.is_last    = out_last_reg;

    // The stream position never runs past the configured matrix.
    assert property (@(posedge clk) disable iff (!rst_n) col_ext < nc_eff)
        else $error("column position reached the configured width");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_row_reg <= nr_eff) && (drain_reg <= nc_eff))
        else $error("row or drain position beyond the configured matrix");

    // The final transaction restarts the count for the next matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_reg.kind == STEP_FINAL) && !cfg_we) |=> (peak_total_reg == '0))
        else $error("peak count not cleared after the final result");

    // A drain transaction is only produced once the whole matrix has arrived.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_load && (s1_next.kind == STEP_DRAIN)) |-> (in_row_reg == nr_eff))
        else $error("drain step started before the last row arrived");

    // The final result never reports a peak position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !out_found_reg)
        else $error("final result flagged as a peak");
endmodule
